### rtl/ptpb_pkg.sv
// ----------------------------------------------------------------------------
// ptpb_pkg
// Shared types, widths and codes of the ping-pong transmit buffer.
// ----------------------------------------------------------------------------
package ptpb_pkg;

  // field widths
  localparam int LEN_W  = 12;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 32;
  localparam int ACT_W  = 2;

  // buffer geometry: two buffers share one byte store
  localparam int BUF_BYTES   = 2048;
  localparam int STORE_BYTES = 2 * BUF_BYTES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  localparam logic [LEN_W-1:0] BUF_LEN   = LEN_W'(BUF_BYTES);
  localparam logic [LEN_W-1:0] CAP_RESET = LEN_W'(1280);

  // action codes
  localparam logic [ACT_W-1:0] ACT_START = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DATA  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd2;
  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_DROP  = 3'd1;
  localparam logic [STAT_W-1:0] ST_BUSY  = 3'd2;
  localparam logic [STAT_W-1:0] ST_USAGE = 3'd3;
  localparam logic [STAT_W-1:0] ST_IDLE  = 3'd4;

  // result of one item, minus the byte read from the store
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              tx_valid;
    logic              tx_last;
    logic [CNT_W-1:0]  overflow_count;
    logic [LEN_W-1:0]  fill_level;
  } res_t;

endpackage

### rtl/ptpb_if.sv
// ----------------------------------------------------------------------------
// ptpb_if
// Valid/ready channels for the input items and the result items.
// ----------------------------------------------------------------------------
interface ptpb_in_if import ptpb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [LEN_W-1:0]  length;
  logic              bulk;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, action, length, bulk, data_byte, input ready);
  modport sink   (input valid, action, length, bulk, data_byte, output ready);
endinterface

interface ptpb_out_if import ptpb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              tx_valid;
  logic [BYTE_W-1:0] tx_byte;
  logic              tx_last;
  logic [CNT_W-1:0]  overflow_count;
  logic [LEN_W-1:0]  fill_level;

  modport source (output valid, status, tx_valid, tx_byte, tx_last, overflow_count,
                  fill_level, input ready);
  modport sink   (input valid, status, tx_valid, tx_byte, tx_last, overflow_count,
                  fill_level, output ready);
endinterface

### rtl/ptpb_ram.sv
// ----------------------------------------------------------------------------
// ptpb_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ptpb_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/ptpb_ctrl.sv
// ----------------------------------------------------------------------------
// ptpb_ctrl
// Buffer bookkeeping: reservation, packet writes, flush and drain addressing.
// ----------------------------------------------------------------------------
module ptpb_ctrl import ptpb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  ptpb_in_if.sink           in_ch,
  input  logic              stage_free,
  input  logic              cfg_we,
  input  logic [LEN_W-1:0]  cfg_wdata,
  output logic              accept,
  output res_t              res,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_waddr,
  output logic [BYTE_W-1:0] mem_wdata,
  output logic              mem_re,
  output logic [ADDR_W-1:0] mem_raddr
);

  logic [LEN_W-1:0] normal_cap;
  logic [LEN_W-1:0] fill0, fill0_next;
  logic [LEN_W-1:0] fill1, fill1_next;
  logic             active_sel, active_sel_next;
  logic             drain_busy, drain_busy_next;
  logic [LEN_W-1:0] drain_length, drain_length_next;
  logic [LEN_W-1:0] drain_position, drain_position_next;
  logic [ADDR_W-1:0] write_pointer, write_pointer_next;
  logic [LEN_W-1:0] bytes_remaining, bytes_remaining_next;
  logic             packet_dropping, packet_dropping_next;
  logic [CNT_W-1:0] drop_counter, drop_counter_next;

  logic [LEN_W-1:0]  fill_act;
  logic [LEN_W-1:0]  cap;
  logic [LEN_W:0]    fill_sum;
  logic              fits;
  logic [LEN_W-1:0]  pos_inc;
  logic [ADDR_W-1:0] act_base;
  logic [ADDR_W-1:0] drain_base;
  logic [STAT_W-1:0] status;
  logic              tx_valid;
  logic              tx_last;

  assign in_ch.ready = stage_free;
  assign accept      = in_ch.valid & stage_free;

  // reservation arithmetic
  assign fill_act   = active_sel ? fill1 : fill0;
  assign cap        = (in_ch.bulk || normal_cap >= BUF_LEN) ? BUF_LEN : normal_cap;
  assign fill_sum   = {1'b0, fill_act} + {1'b0, in_ch.length};
  assign fits       = fill_sum <= {1'b0, cap};
  assign pos_inc    = drain_position + LEN_W'(1);
  assign act_base   = active_sel ? ADDR_W'(BUF_BYTES) : '0;
  assign drain_base = active_sel ? '0 : ADDR_W'(BUF_BYTES);

  // next state and result of the item
  always_comb begin
    fill0_next           = fill0;
    fill1_next           = fill1;
    active_sel_next      = active_sel;
    drain_busy_next      = drain_busy;
    drain_length_next    = drain_length;
    drain_position_next  = drain_position;
    write_pointer_next   = write_pointer;
    bytes_remaining_next = bytes_remaining;
    packet_dropping_next = packet_dropping;
    drop_counter_next    = drop_counter;
    status               = ST_OK;
    tx_valid             = 1'b0;
    tx_last              = 1'b0;
    mem_we               = 1'b0;
    mem_re               = 1'b0;
    case (in_ch.action)
      ACT_START: begin
        if (bytes_remaining != '0 || in_ch.length == '0) begin
          status = ST_USAGE;
        end else begin
          bytes_remaining_next = in_ch.length;
          if (!fits) begin
            packet_dropping_next = 1'b1;
            if (drop_counter != '1) begin
              drop_counter_next = drop_counter + CNT_W'(1);
            end
            status = ST_DROP;
          end else begin
            packet_dropping_next = 1'b0;
            write_pointer_next   = act_base + ADDR_W'(fill_act);
            if (active_sel) begin
              fill1_next = fill_sum[LEN_W-1:0];
            end else begin
              fill0_next = fill_sum[LEN_W-1:0];
            end
          end
        end
      end
      ACT_DATA: begin
        if (bytes_remaining == '0) begin
          status = ST_USAGE;
        end else begin
          if (packet_dropping) begin
            status = ST_DROP;
          end else begin
            mem_we             = 1'b1;
            write_pointer_next = write_pointer + ADDR_W'(1);
          end
          bytes_remaining_next = bytes_remaining - LEN_W'(1);
          if (bytes_remaining == LEN_W'(1)) begin
            packet_dropping_next = 1'b0;
          end
        end
      end
      ACT_FLUSH: begin
        if (drain_busy) begin
          status = ST_BUSY;
        end else if (bytes_remaining != '0 && !packet_dropping) begin
          status = ST_USAGE;
        end else if (fill_act != '0) begin
          drain_length_next   = fill_act;
          drain_position_next = '0;
          drain_busy_next     = 1'b1;
          active_sel_next     = ~active_sel;
          if (active_sel) begin
            fill0_next = '0;
          end else begin
            fill1_next = '0;
          end
        end
      end
      default: begin
        if (!drain_busy) begin
          status = ST_IDLE;
        end else begin
          mem_re              = 1'b1;
          tx_valid            = 1'b1;
          drain_position_next = pos_inc;
          if (pos_inc >= drain_length) begin
            tx_last         = 1'b1;
            drain_busy_next = 1'b0;
          end
        end
      end
    endcase
    mem_we = mem_we & accept;
    mem_re = mem_re & accept;
  end

  // store ports: writes go to the active half, the drain reads the other one
  assign mem_waddr = write_pointer;
  assign mem_wdata = in_ch.data_byte;
  assign mem_raddr = drain_base + ADDR_W'(drain_position);

  // result fields
  assign res.status         = status;
  assign res.tx_valid       = tx_valid;
  assign res.tx_last        = tx_last;
  assign res.overflow_count = drop_counter_next;
  assign res.fill_level     = active_sel_next ? fill1_next : fill0_next;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill0           <= '0;
      fill1           <= '0;
      active_sel      <= 1'b0;
      drain_busy      <= 1'b0;
      drain_length    <= '0;
      drain_position  <= '0;
      write_pointer   <= '0;
      bytes_remaining <= '0;
      packet_dropping <= 1'b0;
      drop_counter    <= '0;
    end else if (accept) begin
      fill0           <= fill0_next;
      fill1           <= fill1_next;
      active_sel      <= active_sel_next;
      drain_busy      <= drain_busy_next;
      drain_length    <= drain_length_next;
      drain_position  <= drain_position_next;
      write_pointer   <= write_pointer_next;
      bytes_remaining <= bytes_remaining_next;
      packet_dropping <= packet_dropping_next;
      drop_counter    <= drop_counter_next;
    end
  end

  // cap register
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_cap <= CAP_RESET;
    end else if (cfg_we) begin
      normal_cap <= cfg_wdata;
    end
  end

endmodule

### rtl/ptpb_out.sv
// ----------------------------------------------------------------------------
// ptpb_out
// Result stage that meets the store read data, followed by an output register.
// ----------------------------------------------------------------------------
module ptpb_out import ptpb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  res_t              res,
  input  logic [BYTE_W-1:0] rdata,
  output logic              stage_free,
  ptpb_out_if.source        out_ch
);

  logic              s1_valid;
  res_t              s1_res;
  logic              s1_move;
  logic              out_valid;
  res_t              out_res;
  logic [BYTE_W-1:0] out_byte;

  // the stage moves on when the output register is empty or being taken
  assign s1_move    = s1_valid & (~out_valid | out_ch.ready);
  assign stage_free = ~s1_valid | s1_move;

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload; the store read data lines up with the first stage
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res <= res;
    end
    if (s1_move) begin
      out_res  <= s1_res;
      out_byte <= s1_res.tx_valid ? rdata : '0;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.status         = out_res.status;
  assign out_ch.tx_valid       = out_res.tx_valid;
  assign out_ch.tx_byte        = out_byte;
  assign out_ch.tx_last        = out_res.tx_last;
  assign out_ch.overflow_count = out_res.overflow_count;
  assign out_ch.fill_level     = out_res.fill_level;

endmodule

### rtl/ping_pong_tx_buffer_with_reserve_top.sv
// ----------------------------------------------------------------------------
// ping_pong_tx_buffer_with_reserve_top
// Double-buffered transmit store with a normal-packet cap and a bulk reserve.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one item per handshake: packet start (length, bulk),
//          data byte, flush, or drain tick.
//   out_ch returns exactly one result item for every input item, in order:
//          status, the drained byte with its last flag, the drop count and
//          the fill level of the active buffer.
//   cfg_we/cfg_wdata write normal_cap; write it only while the block is idle.
// Path: an accepted item is registered in the result stage, then in the
//   output register; the byte store read of a drain tick fills the former.
// Throughput: one item per cycle unless out_ch stalls; each item does at
//   most one store write (data byte) or one store read (drain tick) on a simple dual-port RAM.
// Reset: control state clears, normal_cap returns to 1280, both buffers are
//   empty; the byte store is not cleared and only written bytes are drained.
// Stall: a stalled out_ch holds its result while one more item is taken into
//   the result stage; after that in_ch.ready drops until out_ch moves.
// ----------------------------------------------------------------------------
module ping_pong_tx_buffer_with_reserve_top import ptpb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  ptpb_in_if.sink          in_ch,
  ptpb_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata
);

  logic              accept;
  logic              stage_free;
  res_t              res;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  // bookkeeping and store addressing
  ptpb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .stage_free (stage_free),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr)
  );

  // byte store holding both buffers
  ptpb_ram #(
    .DEPTH (STORE_BYTES),
    .WIDTH (BYTE_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result stage and output register
  ptpb_out u_out (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .res        (res),
    .rdata      (mem_rdata),
    .stage_free (stage_free),
    .out_ch     (out_ch)
  );

endmodule
